### hw/rtl/afd_pkg.sv
// Shared types and constants for the frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

  localparam logic [7:0] START_DELIM_RESET = 8'h7E;
  localparam logic [7:0] SUM_GOOD          = 8'hFF;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_BADSUM    = 3'd2,
    KIND_BADSTART  = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_t;

  // Classified beat handed from front to back.
  typedef struct packed {
    logic       timeout;
    logic       delim_hit;
    logic [7:0] data;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/afd_if.sv
// Stream interfaces for received beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface afd_rx_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface afd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input frame_length, output ready);
endinterface
`default_nettype wire

### hw/rtl/afd_front.sv
// Front end: delimiter register, beat classification and command queue.
`timescale 1ns / 1ps
`default_nettype none
module afd_front
  import afd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [7:0] cfg_wdata,
  afd_rx_if.sink     rx,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  wire logic  q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       delim_reg;
  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             cmd_in;
  logic             push;

  assign rx.ready = (count != CNT_W'(DEPTH));
  assign push     = rx.valid && rx.ready;
  assign q_valid  = (count != '0);
  assign q_cmd    = mem[rd_ptr];

  always_comb begin
    cmd_in.timeout   = rx.op;
    cmd_in.delim_hit = (rx.rx_byte == delim_reg);
    cmd_in.data      = rx.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_reg <= START_DELIM_RESET;
    end else if (cfg_we) begin
      delim_reg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/afd_back.sv
// Back end: frame parser state machine and result output register.
`timescale 1ns / 1ps
`default_nettype none
module afd_back
  import afd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  afd_res_if.source res
);

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] received_count, received_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        res_valid;
  kind_t       kind, kind_next;
  logic [7:0]  payload_byte, payload_byte_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] frame_length, frame_length_next;
  logic        emit;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [7:0]  sum_chk;

  // Output slot is free or drains this cycle.
  assign q_pop = q_valid && (!res_valid || res.ready);

  assign len_full  = {length_reg[15:8], q_cmd.data};
  assign count_inc = received_count + 16'd1;
  assign sum_chk   = running_sum + q_cmd.data;

  always_comb begin
    phase_next          = phase;
    length_reg_next     = length_reg;
    received_count_next = received_count;
    running_sum_next    = running_sum;
    emit                = 1'b0;
    kind_next           = KIND_DATA;
    payload_byte_next   = 8'd0;
    byte_index_next     = received_count;
    frame_length_next   = length_reg;
    if (q_pop) begin
      if (q_cmd.timeout) begin
        if (phase != PH_WAIT) begin
          emit      = 1'b1;
          kind_next = KIND_TRUNC;
        end
        phase_next = PH_WAIT;
      end else begin
        unique case (phase)
          PH_LEN_HI: begin
            length_reg_next = {q_cmd.data, 8'd0};
            phase_next      = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            length_reg_next     = len_full;
            received_count_next = '0;
            running_sum_next    = '0;
            phase_next          = (len_full == 16'd0) ? PH_CSUM : PH_DATA;
          end
          PH_DATA: begin
            emit                = 1'b1;
            kind_next           = KIND_DATA;
            payload_byte_next   = q_cmd.data;
            running_sum_next    = sum_chk;
            received_count_next = count_inc;
            if (count_inc == length_reg) begin
              phase_next = PH_CSUM;
            end
          end
          PH_CSUM: begin
            emit       = 1'b1;
            kind_next  = (sum_chk == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
            phase_next = PH_WAIT;
          end
          default: begin
            if (q_cmd.delim_hit) begin
              length_reg_next     = '0;
              received_count_next = '0;
              running_sum_next    = '0;
              phase_next          = PH_LEN_HI;
            end else begin
              emit              = 1'b1;
              kind_next         = KIND_BADSTART;
              byte_index_next   = '0;
              frame_length_next = '0;
              phase_next        = PH_WAIT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      length_reg     <= '0;
      received_count <= '0;
      running_sum    <= '0;
      res_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      length_reg     <= length_reg_next;
      received_count <= received_count_next;
      running_sum    <= running_sum_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (emit) begin
      kind         <= kind_next;
      payload_byte <= payload_byte_next;
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.kind         = kind;
  assign res.payload_byte = payload_byte;
  assign res.byte_index   = byte_index;
  assign res.frame_length = frame_length;

endmodule
`default_nettype wire

### hw/rtl/api_frame_deframer_top.sv
// Top level of the delimited frame deframer.
//
// Deframer for serial API frames: start delimiter, 16-bit big-endian length
// N, N data bytes, one checksum byte. Each rx beat carries either a received
// byte (op = 0) or a receive-timeout tick (op = 1). Every data byte is
// streamed out as a kind-0 beat with its index and the frame length; the
// checksum byte closes the frame with kind 1 (good: low byte of data sum plus
// checksum is 0xFF) or kind 2 (bad checksum). A byte other than the start
// delimiter while hunting gives kind 3; a timeout inside a frame gives kind 4
// with the count and length seen so far. Delimiter and length bytes and
// timeouts while hunting produce no result beat.
// Rate: one rx beat per cycle sustained while res is ready. An accepted beat
// lands in a small command queue in the front end (delimiter compare done
// there), and the back end's state machine retires one queued command per
// cycle into the result register, which drives res. The back end pops only
// when the result register is empty or draining, so res stalls back up
// through the queue to rx.ready without dropping beats.
// Config: cfg_we/cfg_wdata write the start delimiter (reset 0x7E); write it
// only while the block is idle. rst is synchronous, active high.
`timescale 1ns / 1ps
`default_nettype none
module api_frame_deframer_top
  import afd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH  // command queue entries, >= 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  afd_rx_if.sink          rx,
  afd_res_if.source       res
);

  // Front-to-back command handoff.
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  afd_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rx       (rx),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  afd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .res    (res)
  );

endmodule
`default_nettype wire

### hw/rtl/afd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module afd_checker
  import afd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  kind,
  input wire logic [7:0]  payload_byte,
  input wire logic [15:0] byte_index,
  input wire logic [15:0] frame_length
);

  // Stalled result beat holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(payload_byte)
      && $stable(byte_index) && $stable(frame_length))
    else $error("result beat changed while stalled");

  a_rst_clear: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_DATA |-> payload_byte == 8'd0)
    else $error("status beat carries a payload byte");

  a_badstart: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_BADSTART |-> byte_index == 16'd0 && frame_length == 16'd0)
    else $error("bad start beat has nonzero index or length");

  a_data_idx: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_DATA |-> byte_index < frame_length)
    else $error("data byte index beyond frame length");

endmodule

bind api_frame_deframer_top afd_checker u_afd_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .kind        (res.kind),
  .payload_byte(res.payload_byte),
  .byte_index  (res.byte_index),
  .frame_length(res.frame_length)
);
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the serial API frame deframer.
`timescale 1ns / 1ps
module tb;
  import afd_pkg::*;

  // rx beat opcodes
  localparam bit OP_BYTE    = 1'b0;
  localparam bit OP_TIMEOUT = 1'b1;

  // Cycles to let the block settle once nothing is expected. Delimiter and length
  // beats leave no result, so a few queue entries may still be in flight after
  // the last result.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;  // one long result-side stall
  localparam int unsigned MAX_BODY      = 48;   // most data bytes actually sent per frame
  localparam int unsigned PHASE_BEATS   = 475;  // rx beats per delimiter setting

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CSUM
  } deframe_phase_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  payload;
    logic [15:0] index;
    logic [15:0] length;
  } result_beat_t;

  // Tracks the deframer state from accepted rx beats and holds the result
  // beats that those beats must produce, oldest first.
  class deframe_scoreboard;
    logic [7:0]     delim = START_DELIM_RESET;
    deframe_phase_t phase = PH_HUNT;
    logic [15:0]    frame_len = '0;
    logic [15:0]    byte_count = '0;
    logic [7:0]     byte_sum = '0;
    result_beat_t   expected_results[$];
    int unsigned    errors = 0;
    int unsigned    checked = 0;
    int unsigned    per_kind[5] = '{default: 0};

    function void expect_beat(kind_t k, logic [7:0] p, logic [15:0] i, logic [15:0] l);
      result_beat_t r;
      r.kind    = k;
      r.payload = p;
      r.index   = i;
      r.length  = l;
      expected_results = {expected_results, r};
    endfunction

    // Returns 0 for a beat the deframer ignores (timeout while hunting).
    function bit predict_rx(bit op, logic [7:0] b);
      logic [7:0] total;
      if (op == OP_TIMEOUT) begin
        if (phase == PH_HUNT) return 1'b0;
        expect_beat(KIND_TRUNC, 8'h00, byte_count, frame_len);
        phase = PH_HUNT;
        return 1'b1;
      end
      case (phase)
        PH_LEN_HI: begin
          frame_len = {b, 8'h00};
          phase     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len[7:0] = b;
          byte_count     = '0;
          byte_sum       = '0;
          phase          = (frame_len == 16'd0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          expect_beat(KIND_DATA, b, byte_count, frame_len);
          byte_sum   = byte_sum + b;
          byte_count = byte_count + 16'd1;
          if (byte_count == frame_len) phase = PH_CSUM;
        end
        PH_CSUM: begin
          total = byte_sum + b;
          expect_beat((total == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM, 8'h00, byte_count,
                      frame_len);
          phase = PH_HUNT;
        end
        default: begin
          if (b == delim) begin
            frame_len  = '0;
            byte_count = '0;
            byte_sum   = '0;
            phase      = PH_LEN_HI;
          end else begin
            expect_beat(KIND_BADSTART, 8'h00, 16'd0, 16'd0);
          end
        end
      endcase
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                 $time, name, exp_v, exp_v, got_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] p, logic [15:0] i, logic [15:0] l);
      result_beat_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, kind %0d byte 0x%02h index %0d len %0d",
                 $time, k, p, i, l);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("kind", 16'(e.kind), 16'(k));
      compare_field("payload_byte", 16'(e.payload), 16'(p));
      compare_field("byte_index", e.index, i);
      compare_field("frame_length", e.length, l);
      checked++;
      if (e.kind <= KIND_TRUNC) per_kind[e.kind]++;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  afd_rx_if  rx_if ();
  afd_res_if res_if ();

  api_frame_deframer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_if),
    .res       (res_if)
  );

  deframe_scoreboard deframe_sb = new();

  int unsigned rx_beats   = 0;     // accepted beats that the deframer acts on
  bit          rx_steady  = 1'b0;  // back-to-back offering for the current frame
  bit          hold_armed = 1'b0;  // asks the result side for one long stall

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sender gap: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one rx beat, hold it until accepted, then note it and maybe idle.
  // valid stays high into the next beat when no gap is picked.
  task automatic send_beat(input bit op, input logic [7:0] b);
    int unsigned gap;
    rx_if.valid   <= 1'b1;
    rx_if.op      <= op;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    if (deframe_sb.predict_rx(op, b)) rx_beats++;
    gap = rx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Delimiter, length, data and checksum. With cut set, a timeout lands at a
  // random point after the delimiter instead of the rest of the frame. Long
  // length fields only go out cut, so the data sent stays short.
  task automatic send_frame(input logic [15:0] len, input bit good_sum, input bit cut);
    logic [7:0]  body[$];
    logic [7:0]  d;
    logic [7:0]  s;
    logic [7:0]  good;
    logic [7:0]  csum;
    int unsigned keep;
    s = 8'h00;
    body = {body, len[15:8]};
    body = {body, len[7:0]};
    for (int i = 0; i < int'(len) && i < int'(MAX_BODY); i++) begin
      d = 8'($urandom_range(0, 255));
      body = {body, d};
      s = s + d;
    end
    if (len <= 16'(MAX_BODY)) begin
      good = 8'hFF - s;
      csum = 8'($urandom_range(0, 255));
      if (good_sum) csum = good;
      else if (csum == good) csum = csum ^ 8'h01;
      body = {body, csum};
    end
    keep = cut ? $urandom_range(0, body.size() - 1) : body.size();
    send_beat(OP_BYTE, deframe_sb.delim);
    for (int i = 0; i < int'(keep); i++) send_beat(OP_BYTE, body[i]);
    if (cut) send_beat(OP_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  // Stop offering, let every expected result come out, then let the queue
  // empty of beats that make no result.
  task automatic drain();
    rx_if.valid <= 1'b0;
    while (deframe_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_delim(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    deframe_sb.delim = v;
  endtask

  // Mostly well-formed frames with random content and checksum; the rest are
  // cut frames (some with huge length fields), stray bytes and timeouts.
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    stop_at = rx_beats + quota;
    while (rx_beats < stop_at) begin
      rx_steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, MAX_BODY);
        send_frame(16'(len), $urandom_range(0, 3) != 0, 1'b0);
      end else if (r < 82) begin
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
        send_frame(16'(len), 1'b1, 1'b1);
      end else if (r < 93) begin
        send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(OP_TIMEOUT, 8'($urandom_range(0, 255)));
      end
    end
    rx_steady = 1'b0;
    drain();
  endtask

  // Result side: random ready with long runs of no stall, plus the one long
  // hold-off requested by the stimulus so the queue fills and rx backs up.
  initial begin : res_sink
    int unsigned r;
    res_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_armed) begin
        hold_armed = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (r < 55) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 65) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else if (r < 95) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      deframe_sb.check_result(res_if.kind, res_if.payload_byte, res_if.byte_index,
                              res_if.frame_length);
  end

  initial begin : stimulus
    logic [7:0] delim_list[4];
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    rx_if.valid   = 1'b0;
    rx_if.op      = OP_BYTE;
    rx_if.rx_byte = 8'h00;
    delim_list    = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), START_DELIM_RESET};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset delimiter.
    send_beat(OP_TIMEOUT, 8'h00);             // timeout while hunting: ignored
    send_beat(OP_BYTE, 8'h00);                // wrong opening byte
    // zero length, checksum 0xFF: good
    send_beat(OP_BYTE, START_DELIM_RESET);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
    // zero length, checksum 0x00: bad
    send_beat(OP_BYTE, START_DELIM_RESET);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    // two data bytes, good checksum
    send_beat(OP_BYTE, START_DELIM_RESET);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h02);
    send_beat(OP_BYTE, 8'h01);
    send_beat(OP_BYTE, 8'h02);
    send_beat(OP_BYTE, 8'hFC);
    // timeout right after the delimiter
    send_beat(OP_BYTE, START_DELIM_RESET);
    send_beat(OP_TIMEOUT, 8'hFF);
    // timeout after the length high byte: length shows 0x8000
    send_beat(OP_BYTE, START_DELIM_RESET);
    send_beat(OP_BYTE, 8'h80);
    send_beat(OP_TIMEOUT, 8'h00);
    // maximum length, cut after one data byte
    send_beat(OP_BYTE, START_DELIM_RESET);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'hAA);
    send_beat(OP_TIMEOUT, 8'h55);
    drain();

    // Random part over several delimiters, extremes included; the first
    // setting also gets the long result-side stall.
    foreach (delim_list[i]) begin
      write_delim(delim_list[i]);
      if (i == 0) hold_armed = 1'b1;
      run_random(PHASE_BEATS);
    end

    $display("tb: %0d rx beats over the reset and %0d written delimiters, %0d results checked",
             rx_beats, $size(delim_list), deframe_sb.checked);
    $display("tb: data %0d, good %0d, bad checksum %0d, bad start %0d, truncated %0d",
             deframe_sb.per_kind[KIND_DATA], deframe_sb.per_kind[KIND_GOOD],
             deframe_sb.per_kind[KIND_BADSUM], deframe_sb.per_kind[KIND_BADSTART],
             deframe_sb.per_kind[KIND_TRUNC]);
    if (deframe_sb.errors == 0 && deframe_sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### sim.f
hw/rtl/afd_pkg.sv
hw/rtl/afd_if.sv
hw/rtl/afd_front.sv
hw/rtl/afd_back.sv
hw/rtl/api_frame_deframer_top.sv
hw/rtl/afd_checker.sv
test/tb.sv
